// ===== rtl/layer_alpha_compositor_core_assert.svh =====
// Assertion macros for the layer alpha compositor.
// Used by the cell and output stage modules; no other dependencies.
`ifndef LAYER_ALPHA_COMPOSITOR_CORE_ASSERT_SVH
`define LAYER_ALPHA_COMPOSITOR_CORE_ASSERT_SVH

// Clocked assertion, inactive while reset is high.
`define LACC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked in the cycle after the condition.
`define LACC_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/lacc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the layer alpha compositor.
// No dependencies.
package lacc_pkg;

   localparam int LAYER_COUNT  = 3;
   localparam int INPUT_LAYERS = 3;
   localparam int PIXEL_W      = 32;
   localparam int COLOR_W      = 24;
   localparam int CHAN_W       = 8;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_COLOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT     = 2'd1;

   localparam logic [CHAN_W-1:0]  CHAN_MAX       = 8'hff;
   localparam logic [CHAN_W-1:0]  BLACK_LIMIT    = 8'd127;
   localparam logic [COLOR_W-1:0] BASE_COLOR_RST = 24'hffffff;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      logic                              valid;
      logic [COLOR_W-1:0]                color;
      logic [LAYER_COUNT-1:0][PIXEL_W-1:0] pixels;
   } stage_type;

   // Exact x/255 for x up to 255*255.
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return sum[15:8];
   endfunction

   function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] p,
                                                     input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] c);
      logic [15:0] prod_p;
      logic [15:0] prod_c;
      prod_p = {8'd0, p} * {8'd0, a};
      prod_c = {8'd0, c} * {8'd0, CHAN_MAX - a};
      return div255(prod_p + prod_c);
   endfunction

endpackage

// ===== rtl/lacc_blend_cell.sv =====
// One compositing cell: blends the bottom pending layer into the running color.
// Depends on lacc_pkg and the assertion macro header.
`include "layer_alpha_compositor_core_assert.svh"

module lacc_blend_cell
   import lacc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type stage_in,
   output stage_type stage_out
);

   stage_type          stage_ff;
   stage_type          stage_in_w;
   pixel_type          px;
   logic [CHAN_W-1:0]  alpha;
   logic [COLOR_W-1:0] blended;

   assign px    = stage_in.pixels[LAYER_COUNT-1];
   assign alpha = px[CHAN_W-1:0];

   always_comb begin
      blended[23:16] = mix_channel(px[31:24], alpha, stage_in.color[23:16]);
      blended[15:8]  = mix_channel(px[23:16], alpha, stage_in.color[15:8]);
      blended[7:0]   = mix_channel(px[15:8],  alpha, stage_in.color[7:0]);
   end

   always_comb begin
      stage_in_w.valid  = stage_in.valid;
      stage_in_w.color  = blended;
      stage_in_w.pixels = stage_in.pixels << PIXEL_W;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.color  <= stage_in_w.color;
         stage_ff.pixels <= stage_in_w.pixels;
      end
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_w.valid;
      end
   end

   assign stage_out = stage_ff;

   `LACC_ASSERT_NEXT(a_cell_forward, advance && stage_in.valid, stage_ff.valid, "cell dropped transaction")
   `LACC_ASSERT_NEXT(a_cell_opaque, advance && alpha == CHAN_MAX, stage_ff.color == $past(px[31:8]), "opaque layer not copied")
   `LACC_ASSERT_NEXT(a_cell_clear, advance && alpha == '0, stage_ff.color == $past(stage_in.color), "transparent layer altered color")

endmodule

// ===== rtl/lacc_out_stage.sv =====
// Output stage: optional inversion, gray value, black flag, result register.
// Depends on lacc_pkg and the assertion macro header.
`include "layer_alpha_compositor_core_assert.svh"

module lacc_out_stage
   import lacc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              invert,
   input  stage_type         stage_in,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [CHAN_W-1:0] rsp_red,
   output logic [CHAN_W-1:0] rsp_green,
   output logic [CHAN_W-1:0] rsp_blue,
   output logic [CHAN_W-1:0] rsp_gray,
   output logic              rsp_is_black
);

   logic [CHAN_W-1:0] red_in,  green_in,  blue_in,  gray_in;
   logic [CHAN_W-1:0] red_ff,  green_ff,  blue_ff,  gray_ff;
   logic              valid_ff, black_ff, black_in;
   logic [15:0]       luma;

   always_comb begin
      red_in   = stage_in.color[23:16];
      green_in = stage_in.color[15:8];
      blue_in  = stage_in.color[7:0];
      if (invert) begin
         red_in   = CHAN_MAX - red_in;
         green_in = CHAN_MAX - green_in;
         blue_in  = CHAN_MAX - blue_in;
      end
      luma     = 16'd77 * {8'd0, red_in} + 16'd150 * {8'd0, green_in}
               + 16'd28 * {8'd0, blue_in};
      gray_in  = div255(luma);
      black_in = gray_in < BLACK_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         gray_ff  <= gray_in;
         black_ff <= black_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_red      = red_ff;
   assign rsp_green    = green_ff;
   assign rsp_blue     = blue_ff;
   assign rsp_gray     = gray_ff;
   assign rsp_is_black = black_ff;

   `LACC_ASSERT(a_out_black, !valid_ff || (black_ff == (gray_ff < BLACK_LIMIT)), "black flag mismatch")
   `LACC_ASSERT_NEXT(a_out_hold, valid_ff && !rsp_ready, valid_ff && $stable(gray_ff), "stalled result lost")
   `LACC_ASSERT(a_out_advance, advance == (!valid_ff || rsp_ready), "stage advanced under stall")

endmodule

// ===== rtl/layer_alpha_compositor_core.sv =====
// Top level of the layer alpha compositor: config registers, cell chain, output stage.
// Depends on lacc_pkg, lacc_blend_cell and lacc_out_stage.
//
// Usage:
//   req_*  : one transaction carries the RGBA pixels of all layers at one
//            position (layer 0 on top), packed R,G,B,alpha from the top byte.
//   rsp_*  : one transaction per request: red, green, blue, gray, is_black.
//   csr_*  : register writes, always ready; index 0 base color, 1 invert.
//            Write only while no request is in flight.
//   Pipeline: from request to result, one cell register per layer, then
//   the output register. Throughput: one pixel per cycle while rsp_ready
//   does not stall the chain; the chain of cells moves all in lockstep.
//   Stall: when the result is held by rsp_ready low, the whole chain holds
//   and req_ready drops; a waiting result never blocks a new request while
//   the output register is free or being emptied.
//   Reset: clears all valid bits, base color to white, invert off.

module layer_alpha_compositor_core
   import lacc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIXEL_W-1:0]     req_layer0_pixel,
   input  logic [PIXEL_W-1:0]     req_layer1_pixel,
   input  logic [PIXEL_W-1:0]     req_layer2_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAN_W-1:0]      rsp_red,
   output logic [CHAN_W-1:0]      rsp_green,
   output logic [CHAN_W-1:0]      rsp_blue,
   output logic [CHAN_W-1:0]      rsp_gray,
   output logic                   rsp_is_black,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data
);

   logic [COLOR_W-1:0] base_color_ff, base_color_in;
   logic               invert_ff, invert_in;
   logic               advance;
   pixel_type          in_pixels [INPUT_LAYERS];
   stage_type          chain [LAYER_COUNT+1];
   stage_type          chain_head;

   assign csr_ready = 1'b1;

   always_comb begin
      base_color_in = base_color_ff;
      invert_in     = invert_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_COLOR: base_color_in = csr_data;
            CSR_INVERT:     invert_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_color_ff <= BASE_COLOR_RST;
         invert_ff     <= 1'b0;
      end else begin
         base_color_ff <= base_color_in;
         invert_ff     <= invert_in;
      end
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign in_pixels[0] = req_layer0_pixel;
   assign in_pixels[1] = req_layer1_pixel;
   assign in_pixels[2] = req_layer2_pixel;

   // Bottom layer sits in the top slot; each cell consumes it and shifts.
   always_comb begin
      chain_head.valid = req_valid && req_ready;
      chain_head.color = base_color_ff;
      for (int l = 0; l < LAYER_COUNT; l++) begin
         chain_head.pixels[l] = (l < INPUT_LAYERS) ? in_pixels[l] : '0;
      end
   end

   assign chain[0] = chain_head;

   for (genvar i = 0; i < LAYER_COUNT; i++) begin : g_cell
      lacc_blend_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   lacc_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .invert       (invert_ff),
      .stage_in     (chain[LAYER_COUNT]),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_red      (rsp_red),
      .rsp_green    (rsp_green),
      .rsp_blue     (rsp_blue),
      .rsp_gray     (rsp_gray),
      .rsp_is_black (rsp_is_black)
   );

endmodule
